### sv/swbs_pkg.sv
// Shared types, constants and a function for the sliding window bit similarity search.
package swbs_pkg;

	localparam int WORD_W      = 32;
	localparam int PAT_IDX_W   = 7;
	localparam int CFG_W       = 8;
	localparam int SCORE_OUT_W = 13;

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_REPORT  = 2'd3;

	typedef struct packed {
		logic [1:0]           op;
		logic [PAT_IDX_W-1:0] pattern_index;
		logic [WORD_W-1:0]    value;
	} swbs_in_t;

	typedef struct packed {
		logic [WORD_W-1:0]      window_start;
		logic [SCORE_OUT_W-1:0] best_score;
		logic                   found;
		logic                   overflowed;
		logic                   last;
	} swbs_out_t;

	typedef struct packed {
		logic                 shift;
		logic [WORD_W-1:0]    word;
		logic                 pat_we;
		logic [PAT_IDX_W-1:0] pat_idx;
	} swbs_chain_ctl_t;

	function automatic logic [5:0] ones32(input logic [WORD_W-1:0] x);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + 6'(x[i]);
		end
		return n;
	endfunction

endpackage

### sv/swbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module swbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/swbs_cell.sv
// One pattern cell: holds a pattern word and adds its bit agreement to the passing partial sum.
module swbs_cell import swbs_pkg::*; #(
	parameter int INDEX = 0,
	parameter int SUM_W = 13
) (
	input  logic            clk,
	input  swbs_chain_ctl_t ctl,
	input  logic [SUM_W-1:0] sum_in,
	output logic [SUM_W-1:0] sum_out
);

	localparam bit WRITABLE = (INDEX < (1 << PAT_IDX_W));

	logic [WORD_W-1:0] pattern_q;
	logic [SUM_W-1:0]  sum_q;
	logic [5:0]        agree;

	assign agree = ones32(~(pattern_q ^ ctl.word));

	always_ff @(posedge clk) begin
		if (ctl.pat_we && WRITABLE && (ctl.pat_idx == PAT_IDX_W'(INDEX))) begin
			pattern_q <= ctl.word;
		end
		if (ctl.shift) begin
			sum_q <= sum_in + SUM_W'(agree);
		end
	end

	assign sum_out = sum_q;

endmodule

### sv/sliding_window_bit_similarity_search.sv
// Top level of the sliding window bit similarity search over a row of pattern cells.
//
// Items arrive on item_valid/item_ready with an op, a pattern index and a value; results
// leave on result_valid/result_ready; pattern_length is written on cfg_valid/cfg_ready,
// which is always ready. A data word is taken every cycle while the state is idle: each
// cell adds its agreement with the broadcast word to the partial sum from its neighbor,
// and the score of the window ending at that word passes score stages s1 and s2 before
// it is judged. Pattern writes, clears and reports wait until those two score stages
// have drained. A pattern write while data words are held replays them from the ring
// memory through the cells, one word a cycle. A report reads each hit from the hit list
// memory in S_REP_RD and loads it into the output register in S_REP_LD, so its results
// are paced by the registered read; a report with no hits gives one result.
// A stalled receiver holds the output register, and the report waits on it; other
// items are still taken once the final result of a report is loaded.
// Reset empties the scan, sets pattern_length to one and leaves pattern words undefined
// until written; there is no clearing pass.
module sliding_window_bit_similarity_search import swbs_pkg::*; #(
	parameter int MAX_PATTERN = 128,
	parameter int MAX_HITS    = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  swbs_in_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output swbs_out_t        result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FW  = $clog2(MAX_PATTERN + 1);
	localparam int LW  = (FW > CFG_W) ? FW : CFG_W;
	localparam int SW  = $clog2(WORD_W * MAX_PATTERN + 1);
	localparam int HAW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int HCW = $clog2(MAX_HITS + 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_REPLAY = 2'd1;
	localparam logic [1:0] S_REP_RD = 2'd2;
	localparam logic [1:0] S_REP_LD = 2'd3;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  plen_q;
	logic [FW-1:0]     len;
	logic [AW-1:0]     sel;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_nxt;
	logic [AW-1:0]     ring_pos_q;
	logic [WORD_W-1:0] words_q;
	logic [SW-1:0]     top_q;
	logic [HCW-1:0]    hc_q;
	logic              ovf_q;

	logic              valid_s1;
	logic [WORD_W-1:0] start_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] start_s2;
	logic [SW-1:0]     score_s2;

	logic [AW-1:0]     rp_addr_q;
	logic [FW-1:0]     rp_left_q;
	logic              rp_pend_q;
	logic [AW:0]       rp_base_sum;
	logic [AW-1:0]     rp_base;

	logic [HCW-1:0]    rep_idx_q;
	logic              rep_empty_q;
	logic              rep_last;
	logic              res_load;
	logic              res_valid_q;
	swbs_out_t         res_q;

	logic              acc;
	logic              data_acc;
	logic              pat_acc;
	logic              pipe_busy;

	logic              ring_re;
	logic [WORD_W-1:0] ring_rdata;
	logic              hit_we;
	logic [HAW-1:0]    hit_waddr;
	logic              hit_re;
	logic [WORD_W-1:0] hit_rdata;

	swbs_chain_ctl_t   chain_ctl;
	logic [SW-1:0]     sums [MAX_PATTERN];

	always_comb begin
		if (plen_q == '0) begin
			len = FW'(1);
		end else if (LW'(plen_q) > LW'(MAX_PATTERN)) begin
			len = FW'(MAX_PATTERN);
		end else begin
			len = FW'(plen_q);
		end
	end

	assign sel       = AW'(len - FW'(1));
	assign pipe_busy = valid_s1 | valid_s2;
	assign item_ready = (state_q == S_IDLE) && ((item.op == OP_DATA) || !pipe_busy);
	assign acc       = item_valid && item_ready;
	assign data_acc  = acc && (item.op == OP_DATA);
	assign pat_acc   = acc && (item.op == OP_PATTERN)
		&& (32'(item.pattern_index) < MAX_PATTERN);
	assign fill_nxt  = (fill_q == FW'(MAX_PATTERN)) ? fill_q : fill_q + FW'(1);
	assign cfg_ready = 1'b1;

	assign rp_base_sum = {1'b0, ring_pos_q} + (AW + 1)'(MAX_PATTERN) - (AW + 1)'(fill_q);
	assign rp_base = (rp_base_sum >= (AW + 1)'(MAX_PATTERN))
		? AW'(rp_base_sum - (AW + 1)'(MAX_PATTERN)) : AW'(rp_base_sum);

	assign ring_re = (state_q == S_REPLAY) && (rp_left_q != '0);

	assign chain_ctl.shift   = data_acc | rp_pend_q;
	assign chain_ctl.word    = rp_pend_q ? ring_rdata : item.value;
	assign chain_ctl.pat_we  = pat_acc;
	assign chain_ctl.pat_idx = item.pattern_index;

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		logic [SW-1:0] sum_in;
		if (g == 0) begin : g_first
			assign sum_in = '0;
		end else begin : g_next
			assign sum_in = sums[g-1];
		end
		swbs_cell #(
			.INDEX(g),
			.SUM_W(SW)
		) u_cell (
			.clk    (clk),
			.ctl    (chain_ctl),
			.sum_in (sum_in),
			.sum_out(sums[g])
		);
	end

	swbs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_PATTERN)
	) u_ring (
		.clk  (clk),
		.we   (data_acc),
		.waddr(ring_pos_q),
		.wdata(item.value),
		.re   (ring_re),
		.raddr(rp_addr_q),
		.rdata(ring_rdata)
	);

	always_comb begin
		hit_we    = 1'b0;
		hit_waddr = '0;
		if (valid_s2) begin
			if ((hc_q != '0) && (score_s2 == top_q)) begin
				hit_we    = (hc_q < HCW'(MAX_HITS));
				hit_waddr = HAW'(hc_q);
			end else if ((hc_q == '0) || (score_s2 > top_q)) begin
				hit_we = 1'b1;
			end
		end
	end

	assign hit_re = (state_q == S_REP_RD);

	swbs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_HITS)
	) u_hits (
		.clk  (clk),
		.we   (hit_we),
		.waddr(hit_waddr),
		.wdata(start_s2),
		.re   (hit_re),
		.raddr(HAW'(rep_idx_q)),
		.rdata(hit_rdata)
	);

	assign rep_last = rep_empty_q || (HCW'(rep_idx_q + HCW'(1)) == hc_q);
	assign res_load = (state_q == S_REP_LD) && (!res_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			plen_q      <= CFG_W'(1);
			fill_q      <= '0;
			ring_pos_q  <= '0;
			words_q     <= '0;
			top_q       <= '0;
			hc_q        <= '0;
			ovf_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rp_left_q   <= '0;
			rp_pend_q   <= 1'b0;
			rep_idx_q   <= '0;
			rep_empty_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				plen_q <= cfg_data;
			end

			valid_s1 <= data_acc && (fill_nxt >= len);
			valid_s2 <= valid_s1;

			if (valid_s2) begin
				if ((hc_q != '0) && (score_s2 == top_q)) begin
					if (hc_q < HCW'(MAX_HITS)) begin
						hc_q <= hc_q + HCW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end else if ((hc_q == '0) || (score_s2 > top_q)) begin
					top_q <= score_s2;
					hc_q  <= HCW'(1);
					ovf_q <= 1'b0;
				end
			end

			if (data_acc) begin
				ring_pos_q <= (ring_pos_q == AW'(MAX_PATTERN - 1)) ? '0 : ring_pos_q + AW'(1);
				fill_q     <= fill_nxt;
				words_q    <= words_q + 32'd1;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (acc && (item.op == OP_CLEAR)) begin
						fill_q     <= '0;
						ring_pos_q <= '0;
						words_q    <= '0;
						top_q      <= '0;
						hc_q       <= '0;
						ovf_q      <= 1'b0;
					end
					if (pat_acc && (fill_q != '0)) begin
						rp_left_q <= fill_q;
						state_q   <= S_REPLAY;
					end
					if (acc && (item.op == OP_REPORT)) begin
						rep_idx_q   <= '0;
						rep_empty_q <= (hc_q == '0);
						state_q     <= (hc_q == '0) ? S_REP_LD : S_REP_RD;
					end
				end
				S_REPLAY: begin
					rp_pend_q <= (rp_left_q != '0);
					if (rp_left_q != '0) begin
						rp_left_q <= rp_left_q - FW'(1);
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_REP_RD: begin
					state_q <= S_REP_LD;
				end
				S_REP_LD: begin
					if (res_load) begin
						if (rep_last) begin
							state_q <= S_IDLE;
						end else begin
							rep_idx_q <= rep_idx_q + HCW'(1);
							state_q   <= S_REP_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc) begin
			start_s1 <= words_q + 32'd1 - 32'(len);
		end
		start_s2 <= start_s1;
		score_s2 <= sums[sel];

		if (pat_acc) begin
			rp_addr_q <= rp_base;
		end else if (ring_re) begin
			rp_addr_q <= (rp_addr_q == AW'(MAX_PATTERN - 1)) ? '0 : rp_addr_q + AW'(1);
		end

		if (res_load) begin
			res_q.window_start <= rep_empty_q ? '0 : hit_rdata;
			res_q.best_score   <= rep_empty_q ? '0 : SCORE_OUT_W'(top_q);
			res_q.found        <= !rep_empty_q;
			res_q.overflowed   <= rep_empty_q ? 1'b0 : ovf_q;
			res_q.last         <= rep_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
